@@ src/ising_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ising site update shared types
// Spin triples held by the ring of column cells and the control words that
// steer the cells and the row store.
// ----------------------------------------------------------------------------
package ising_pkg;

	typedef struct packed {
		logic up;
		logic cur;
		logic down;
	} spin3_t;

	typedef struct packed {
		logic fill;
		logic fill_val;
		logic shift;
		logic advance;
	} cell_ctrl_t;

	typedef struct packed {
		logic init;
		logic fill_val;
		logic wr_en;
		logic wrap;
	} store_ctrl_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

@@ src/ising_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ising column cell
// Holds the spins of one column in the row above, the current row and the row
// below. Takes its neighbor's triple on a shift, slides down one row on an
// advance and takes the fill spin in all three rows on a fill.
// ----------------------------------------------------------------------------
module ising_cell
	import ising_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  spin3_t     feed,
	input  logic       load_bit,
	output spin3_t     spin,
	output logic       rot_cur
);

	spin3_t spin_q;
	spin3_t rot;

	always_comb begin
		rot = ctrl.shift ? feed : spin_q;
	end

	assign rot_cur = rot.cur;
	assign spin    = spin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q <= '1;
		end else if (ctrl.fill) begin
			spin_q <= '{up: ctrl.fill_val, cur: ctrl.fill_val, down: ctrl.fill_val};
		end else if (ctrl.advance) begin
			spin_q <= '{up: rot.cur, cur: rot.down, down: load_bit};
		end else if (ctrl.shift) begin
			spin_q <= rot;
		end
	end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

@@ src/ising_row_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ising row store
// Lattice memory of one row per word. Prefetches the row two below the current
// one and substitutes the fill spin for rows not written since the last fill.
// ----------------------------------------------------------------------------
module ising_row_store
	import ising_pkg::*;
#(
	parameter int SIDE = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  store_ctrl_t             ctrl,
	input  logic [$clog2(SIDE)-1:0] row,
	input  logic [SIDE-1:0]         wr_data,
	output logic [SIDE-1:0]         next_row
);

	localparam int RW = $clog2(SIDE);

	logic [SIDE-1:0] mem_q [SIDE];
	logic [SIDE-1:0] rd_data_q;
	logic            rd_valid_q;
	logic            all_valid_q;
	logic            fill_q;
	logic [RW:0]     row_p2;
	logic [RW-1:0]   rd_addr;

	always_comb begin
		row_p2 = {1'b0, row} + (RW+1)'(2);
		if (row_p2 >= (RW+1)'(SIDE)) begin
			row_p2 = row_p2 - (RW+1)'(SIDE);
		end
		rd_addr = row_p2[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[row] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q  <= 1'b0;
			all_valid_q <= 1'b0;
			fill_q      <= 1'b1;
		end else begin
			rd_valid_q <= all_valid_q || (rd_addr < row);
			if (ctrl.init) begin
				all_valid_q <= 1'b0;
				fill_q      <= ctrl.fill_val;
			end else if (ctrl.wrap) begin
				all_valid_q <= 1'b1;
			end
		end
	end

	assign next_row = rd_valid_q ? rd_data_q : {SIDE{fill_q}};

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

@@ src/ising_metropolis_site_update_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ising Metropolis site update core
// Visits the sites of a periodic SIDE x SIDE lattice in raster order and
// takes one site update or lattice fill per transfer, one transfer per clock
// back to back unless the output stalls; each result passes the stage 1 and
// stage 2 registers. The current row sits in a ring of SIDE column cells that
// rotates by one column per update, so the site and its four neighbors are
// always at fixed cells and the flip decision is combinational. The lattice
// memory holds one row per word and sees prefetch reads and one write back
// per row. A fill is one transfer: rows not yet rewritten since the fill read
// as the fill spin, so there is no clearing pass after reset or fill.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_core
	import ising_pkg::*;
#(
	parameter int SIDE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               command,
	input  logic               start_spin,
	input  logic [15:0]        random_fraction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [5:0]         row,
	output logic [5:0]         column,
	output logic               spin_after,
	output logic               flipped,
	output logic signed [31:0] energy,
	output logic signed [13:0] magnetization,
	output logic               sweep_done
);

	localparam int RW        = $clog2(SIDE);
	localparam int SITES     = SIDE * SIDE;
	localparam int POS_OUT_W = 6;
	localparam int MAG_W     = 14;
	localparam int ENERGY_W  = 32;
	localparam int THR_W     = 16;
	localparam int THR_N     = 10;
	localparam int SUM_W     = 19;
	localparam int DE_W      = 20;
	localparam int SITES_W   = $clog2(SITES) + 2;
	localparam int PROD_W    = DE_W + SITES_W;
	localparam int SAT_W     = (PROD_W > 33) ? PROD_W : 33;

	localparam logic [RW-1:0]              LAST       = RW'(SIDE - 1);
	localparam logic [MAG_W-1:0]           MAG_UP     = MAG_W'(SITES);
	localparam logic [MAG_W-1:0]           MAG_DN     = MAG_W'(-SITES);
	localparam logic signed [SITES_W-1:0]  NEG_SITES  = SITES_W'(-SITES);
	localparam logic signed [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-(SITES * 512));
	localparam logic signed [ENERGY_W-1:0] E_MAX      = 32'sh7FFFFFFF;
	localparam logic signed [ENERGY_W-1:0] E_MIN      = 32'sh80000000;
	localparam logic signed [SAT_W-1:0]    E_HI       = SAT_W'(E_MAX);
	localparam logic signed [SAT_W-1:0]    E_LO       = SAT_W'(E_MIN);

	localparam logic       CMD_INIT       = 1'b0;
	localparam logic       CMD_UPDATE     = 1'b1;
	localparam logic [2:0] REG_COUPLING   = 3'd0;
	localparam logic [2:0] REG_FIELD      = 3'd1;
	localparam logic [2:0] REG_THR_LOW    = 3'd2;
	localparam logic [2:0] REG_THR_MID    = 3'd3;
	localparam logic [2:0] REG_THR_HIGH   = 3'd4;

	function automatic logic signed [ENERGY_W-1:0] sat_energy(
		input logic signed [SAT_W-1:0] v
	);
		if (v > E_HI) begin
			return E_MAX;
		end else if (v < E_LO) begin
			return E_MIN;
		end
		return ENERGY_W'(v);
	endfunction

	// configuration registers
	logic signed [15:0] coupling_q;
	logic signed [15:0] field_q;
	logic [63:0]        thr_low_q;
	logic [63:0]        thr_mid_q;
	logic [31:0]        thr_high_q;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q <= 16'sd256;
			field_q    <= '0;
			thr_low_q  <= '0;
			thr_mid_q  <= '0;
			thr_high_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_COUPLING: coupling_q <= pwdata[15:0];
				REG_FIELD:    field_q    <= pwdata[15:0];
				REG_THR_LOW:  thr_low_q  <= pwdata;
				REG_THR_MID:  thr_mid_q  <= pwdata;
				REG_THR_HIGH: thr_high_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COUPLING: prdata = {48'd0, coupling_q};
			REG_FIELD:    prdata = {48'd0, field_q};
			REG_THR_LOW:  prdata = thr_low_q;
			REG_THR_MID:  prdata = thr_mid_q;
			REG_THR_HIGH: prdata = {32'd0, thr_high_q};
			default:      prdata = '0;
		endcase
	end

	logic [THR_W-1:0] thr_tab [THR_N];

	always_comb begin
		thr_tab[0] = thr_low_q[15:0];
		thr_tab[1] = thr_low_q[31:16];
		thr_tab[2] = thr_low_q[47:32];
		thr_tab[3] = thr_low_q[63:48];
		thr_tab[4] = thr_mid_q[15:0];
		thr_tab[5] = thr_mid_q[31:16];
		thr_tab[6] = thr_mid_q[47:32];
		thr_tab[7] = thr_mid_q[63:48];
		thr_tab[8] = thr_high_q[15:0];
		thr_tab[9] = thr_high_q[31:16];
	end

	// handshake and pipeline control
	logic valid_s1;
	logic valid_s2;
	logic out_ready;
	logic in_xfer;
	logic adv_s1;
	logic is_init;

	assign out_ready    = !valid_s2 || !result_stall;
	assign item_stall   = valid_s1 && !out_ready;
	assign in_xfer      = item_valid && !item_stall;
	assign adv_s1       = valid_s1 && out_ready;
	assign is_init      = (command == CMD_INIT);
	assign result_valid = valid_s2;

	// site pointer
	logic [RW-1:0] row_q;
	logic [RW-1:0] col_q;
	logic          last_col;
	logic          last_row;

	assign last_col = (col_q == LAST);
	assign last_row = (row_q == LAST);

	// ring of column cells
	cell_ctrl_t      cell_ctrl;
	store_ctrl_t     store_ctrl;
	spin3_t          cell_spin [SIDE];
	logic [SIDE-1:0] rot_cur;
	logic [SIDE-1:0] next_row;
	logic            accept;

	always_comb begin
		cell_ctrl.fill     = in_xfer && is_init;
		cell_ctrl.fill_val = start_spin;
		cell_ctrl.shift    = in_xfer && !is_init;
		cell_ctrl.advance  = in_xfer && !is_init && last_col;
		store_ctrl.init     = cell_ctrl.fill;
		store_ctrl.fill_val = start_spin;
		store_ctrl.wr_en    = cell_ctrl.advance;
		store_ctrl.wrap     = cell_ctrl.advance && last_row;
	end

	for (genvar gi = 0; gi < SIDE; gi++) begin : g_cell
		spin3_t feed;
		if (gi == SIDE - 1) begin : g_tail
			assign feed = '{up: cell_spin[0].up, cur: cell_spin[0].cur ^ accept,
				down: cell_spin[0].down};
		end else begin : g_body
			assign feed = cell_spin[gi+1];
		end
		ising_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.feed     (feed),
			.load_bit (next_row[gi]),
			.spin     (cell_spin[gi]),
			.rot_cur  (rot_cur[gi])
		);
	end

	ising_row_store #(
		.SIDE (SIDE)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (store_ctrl),
		.row      (row_q),
		.wr_data  (rot_cur),
		.next_row (next_row)
	);

	// flip decision
	logic                    s0;
	logic [2:0]              n1;
	logic [3:0]              idx;
	logic signed [SUM_W-1:0] j_ext;
	logic signed [SUM_W-1:0] f_ext;
	logic signed [SUM_W-1:0] jn;
	logic signed [SUM_W-1:0] site_sum;
	logic signed [SUM_W-1:0] init_term;
	logic signed [DE_W-1:0]  dbl;
	logic signed [DE_W-1:0]  de;
	logic                    de_pos;

	always_comb begin
		s0    = cell_spin[0].cur;
		n1    = 3'(cell_spin[0].up) + 3'(cell_spin[0].down) + 3'(cell_spin[1].cur)
			+ 3'(cell_spin[SIDE-1].cur);
		idx   = s0 ? (4'd5 + 4'(n1)) : 4'(n1);
		j_ext = SUM_W'(coupling_q);
		f_ext = SUM_W'(field_q);
		case (n1)
			3'd0:    jn = -(j_ext <<< 2);
			3'd1:    jn = -(j_ext <<< 1);
			3'd3:    jn = j_ext <<< 1;
			3'd4:    jn = j_ext <<< 2;
			default: jn = '0;
		endcase
		site_sum  = jn + f_ext;
		dbl       = DE_W'(site_sum) <<< 1;
		de        = s0 ? dbl : -dbl;
		de_pos    = !de[DE_W-1] && (de != '0);
		accept    = !de_pos || (random_fraction < thr_tab[idx]);
		init_term = (j_ext <<< 1) + (start_spin ? f_ext : -f_ext);
	end

	// stage 1: decision result
	logic [RW-1:0]          row_s1;
	logic [RW-1:0]          col_s1;
	logic                   spin_s1;
	logic                   flip_s1;
	logic                   done_s1;
	logic                   init_s1;
	logic signed [DE_W-1:0] delta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (in_xfer && is_init) begin
				row_q <= '0;
				col_q <= '0;
			end else if (in_xfer) begin
				col_q <= last_col ? '0 : col_q + RW'(1);
				if (last_col) begin
					row_q <= last_row ? '0 : row_q + RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			init_s1 <= is_init;
			if (is_init) begin
				row_s1   <= '0;
				col_s1   <= '0;
				spin_s1  <= start_spin;
				flip_s1  <= 1'b0;
				done_s1  <= 1'b1;
				delta_s1 <= DE_W'(init_term);
			end else begin
				row_s1   <= row_q;
				col_s1   <= col_q;
				spin_s1  <= s0 ^ accept;
				flip_s1  <= accept;
				done_s1  <= last_col && last_row;
				delta_s1 <= de;
			end
		end
	end

	// stage 2: running totals and result
	logic [RW-1:0]              row_s2;
	logic [RW-1:0]              col_s2;
	logic                       spin_s2;
	logic                       flip_s2;
	logic                       done_s2;
	logic signed [ENERGY_W-1:0] energy_q;
	logic [MAG_W-1:0]           mag_q;
	logic signed [SAT_W-1:0]    fill_energy;
	logic signed [SAT_W-1:0]    step_energy;

	always_comb begin
		fill_energy = SAT_W'(delta_s1) * SAT_W'(NEG_SITES);
		step_energy = SAT_W'(energy_q) + SAT_W'(delta_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			energy_q <= ENERGY_RST;
			mag_q    <= MAG_UP;
		end else begin
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1 && init_s1) begin
				energy_q <= sat_energy(fill_energy);
				mag_q    <= spin_s1 ? MAG_UP : MAG_DN;
			end else if (adv_s1 && flip_s1) begin
				energy_q <= sat_energy(step_energy);
				mag_q    <= spin_s1 ? (mag_q + MAG_W'(2)) : (mag_q - MAG_W'(2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			spin_s2 <= spin_s1;
			flip_s2 <= flip_s1;
			done_s2 <= done_s1;
		end
	end

	assign row           = POS_OUT_W'(row_s2);
	assign column        = POS_OUT_W'(col_s2);
	assign spin_after    = spin_s2;
	assign flipped       = flip_s2;
	assign sweep_done    = done_s2;
	assign energy        = energy_q;
	assign magnetization = mag_q;

	a_mag_parity: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q[0] == MAG_UP[0])
		else $error("magnetization parity broken");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_init_origin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && init_s1 |-> row_s1 == '0 && col_s1 == '0 && done_s1 && !flip_s1)
		else $error("fill result not at origin");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && command == CMD_UPDATE && last_col |=> col_q == '0)
		else $error("column pointer did not wrap");

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
